>>> rtl/nsa_pkg.sv
`timescale 1ns / 1ps

package nsa_pkg;

  localparam int NumStates      = 16;
  localparam int MaxTransitions = 64;
  localparam int StateW         = 4;
  localparam int SetW           = 16;
  localparam int SymW           = 8;
  localparam int ActW           = 2;
  localparam int StateLimit     = (NumStates < SetW) ? NumStates : SetW;

  localparam logic [ActW-1:0] ActAdd    = 2'd0;
  localparam logic [ActW-1:0] ActSymbol = 2'd1;
  localparam logic [ActW-1:0] ActClear  = 2'd2;

  localparam logic [SymW-1:0] EmptyMark = 8'h2D;

  typedef struct packed {
    logic [StateW-1:0] src;
    logic [SymW-1:0]   sym;
    logic [StateW-1:0] dst;
  } entry_t;

  typedef struct packed {
    logic            clear;
    logic            step;
    logic [SymW-1:0] sym;
  } follow_ctrl_t;

endpackage

>>> rtl/nsa_trans_ram.sv
`timescale 1ns / 1ps

module nsa_trans_ram #(
  parameter int Depth = nsa_pkg::MaxTransitions,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                we_i,
  input  logic [AddrW-1:0]    waddr_i,
  input  nsa_pkg::entry_t     wdata_i,
  input  logic                re_i,
  input  logic [AddrW-1:0]    raddr_i,
  output nsa_pkg::entry_t     rdata_o,
  output logic                rvalid_o
);

  nsa_pkg::entry_t mem_q [Depth];
  nsa_pkg::entry_t rdata_q;
  logic            rvalid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvalid_q <= 1'b0;
    end else begin
      rvalid_q <= re_i;
    end
  end

  assign rdata_o  = rdata_q;
  assign rvalid_o = rvalid_q;

endmodule

>>> rtl/nsa_follow_unit.sv
`timescale 1ns / 1ps

module nsa_follow_unit (
  input  logic                       clk_i,
  input  nsa_pkg::follow_ctrl_t      ctrl_i,
  input  logic [nsa_pkg::SetW-1:0]   set_i,
  input  nsa_pkg::entry_t            entry_i,
  output logic [nsa_pkg::SetW-1:0]   next_set_o
);

  logic [nsa_pkg::SetW-1:0] acc_q;
  logic [nsa_pkg::SetW-1:0] acc_d;
  logic                     hit;

  assign hit = ctrl_i.step && (entry_i.sym == ctrl_i.sym) && set_i[entry_i.src];

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (hit) begin
      acc_d = acc_q | (nsa_pkg::SetW'(1) << entry_i.dst);
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign next_set_o = acc_q;

endmodule

>>> rtl/nfa_string_acceptor_unit.sv
// Add, clear and unknown items leave the block in idle, so it stays ready for the next item.
// A symbol item passes the scan state, which reads the table one entry per cycle and then
// takes in the last read, then the drain state and the apply state, which applies the result.
// An empty-string marker skips to apply; a string end waits while a result is unread.
// Reset clears the table fill count, sets the active set to state 0 and the mask to 0;
// table contents are undefined until written.
`timescale 1ns / 1ps

module nfa_string_acceptor_unit #(
  parameter int MAX_TRANSITIONS = nsa_pkg::MaxTransitions
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [nsa_pkg::ActW-1:0]    action_i,
  input  logic [nsa_pkg::StateW-1:0]  source_state_i,
  input  logic [nsa_pkg::StateW-1:0]  dest_state_i,
  input  logic [nsa_pkg::SymW-1:0]    symbol_i,
  input  logic                        last_symbol_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        accepted_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [nsa_pkg::SetW-1:0]    accepting_mask_i
);

  localparam int AddrW  = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1;
  localparam int CountW = $clog2(MAX_TRANSITIONS + 1);
  localparam logic [CountW-1:0] CountMax = CountW'(MAX_TRANSITIONS);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDrain,
    StApply
  } state_e;

  state_e                     state_q;
  logic [CountW-1:0]          count_q;
  logic [CountW-1:0]          idx_q;
  logic [nsa_pkg::SetW-1:0]   active_q;
  logic [nsa_pkg::SetW-1:0]   mask_q;
  logic [nsa_pkg::SymW-1:0]   sym_q;
  logic                       last_q;
  logic                       skip_q;
  logic                       out_valid_q;
  logic                       accepted_q;

  logic                       in_fire;
  logic                       add_ok;
  logic                       we;
  logic                       re;
  logic                       out_free;
  logic                       is_marker;
  nsa_pkg::entry_t            wdata;
  nsa_pkg::entry_t            rdata;
  logic                       rvalid;
  nsa_pkg::follow_ctrl_t      fctrl;
  logic [nsa_pkg::SetW-1:0]   next_set;
  logic [nsa_pkg::SetW-1:0]   final_set;

  assign in_ready_o  = (state_q == StIdle);
  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign is_marker   = last_symbol_i && (symbol_i == nsa_pkg::EmptyMark);

  assign add_ok = (count_q < CountMax)
               && (int'(source_state_i) < nsa_pkg::StateLimit)
               && (int'(dest_state_i) < nsa_pkg::StateLimit);
  assign we     = in_fire && (action_i == nsa_pkg::ActAdd) && add_ok;
  assign re     = (state_q == StScan) && (idx_q < count_q);

  assign wdata.src = source_state_i;
  assign wdata.sym = symbol_i;
  assign wdata.dst = dest_state_i;

  assign fctrl.clear = in_fire && (action_i == nsa_pkg::ActSymbol);
  assign fctrl.step  = rvalid;
  assign fctrl.sym   = sym_q;

  assign final_set = skip_q ? active_q : next_set;

  nsa_trans_ram #(
    .Depth (MAX_TRANSITIONS),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .we_i     (we),
    .waddr_i  (count_q[AddrW-1:0]),
    .wdata_i  (wdata),
    .re_i     (re),
    .raddr_i  (idx_q[AddrW-1:0]),
    .rdata_o  (rdata),
    .rvalid_o (rvalid)
  );

  nsa_follow_unit u_follow (
    .clk_i      (clk_i),
    .ctrl_i     (fctrl),
    .set_i      (active_q),
    .entry_i    (rdata),
    .next_set_o (next_set)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      idx_q       <= '0;
      active_q    <= nsa_pkg::SetW'(1);
      mask_q      <= '0;
      sym_q       <= '0;
      last_q      <= 1'b0;
      skip_q      <= 1'b0;
      out_valid_q <= 1'b0;
      accepted_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        mask_q <= accepting_mask_i;
      end
      if (out_valid_q && out_ready_i && !(state_q == StApply && last_q)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_fire) begin
            case (action_i)
              nsa_pkg::ActAdd: begin
                if (add_ok) begin
                  count_q <= count_q + CountW'(1);
                end
              end
              nsa_pkg::ActClear: begin
                count_q <= '0;
              end
              nsa_pkg::ActSymbol: begin
                sym_q  <= symbol_i;
                last_q <= last_symbol_i;
                skip_q <= is_marker;
                idx_q  <= '0;
                state_q <= is_marker ? StApply : StScan;
              end
              default: begin
              end
            endcase
          end
        end
        StScan: begin
          if (idx_q < count_q) begin
            idx_q <= idx_q + CountW'(1);
          end else begin
            state_q <= StDrain;
          end
        end
        StDrain: begin
          state_q <= StApply;
        end
        StApply: begin
          if (!last_q) begin
            active_q <= final_set;
            state_q  <= StIdle;
          end else if (out_free) begin
            out_valid_q <= 1'b1;
            accepted_q  <= |(final_set & mask_q);
            active_q    <= nsa_pkg::SetW'(1);
            state_q     <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign accepted_o  = accepted_q;

endmodule

>>> rtl/nsa_checker.sv
`timescale 1ns / 1ps

module nsa_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic [nsa_pkg::ActW-1:0]    action_i,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic                        accepted_o
);

  // A waiting result holds its value until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(accepted_o))
    else $error("result item changed while stalled");

  // Table loads and clears leave the block ready again in the next cycle.
  a_table_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (action_i == nsa_pkg::ActAdd || action_i == nsa_pkg::ActClear)
    |=> in_ready_o)
    else $error("table item did not complete in one cycle");

  // A symbol item always moves the block out of idle, so it is busy once the item is taken.
  a_symbol_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && action_i == nsa_pkg::ActSymbol |=> !in_ready_o)
    else $error("symbol item did not start a scan");

  // A new result appears only as the block returns to idle.
  a_result_at_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o && !$past(in_ready_o))
    else $error("result item raised outside the end of a symbol");

endmodule

bind nfa_string_acceptor_unit nsa_checker u_nsa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .action_i    (action_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .accepted_o  (accepted_o)
);
